// File: sv/tbss_pkg.sv
// ----------------------------------------------------------------------------
// tbss_pkg: shared types and constants
// Codes, word structs and sizes used by the tape block seek sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package tbss_pkg;

    // Width of the tracked block position (16 to 32)
    localparam int BLOCK_BITS = 32;
    // Fixed widths of the word fields
    localparam int BLOCK_NUM_W = 32;
    localparam int STEP_TIME_W = 16;

    localparam logic [STEP_TIME_W-1:0] REVERSE_STEP_RESET = 16'd600;

    typedef logic [BLOCK_BITS-1:0] block_t;

    typedef enum logic [1:0] {
        REQ_READ       = 2'd0,
        REQ_WRITE      = 2'd1,
        REQ_INVALIDATE = 2'd2,
        REQ_STATUS     = 2'd3
    } req_code_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_PARITY     = 2'd1,
        ST_LOAD_POINT = 2'd2,
        ST_ERROR      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CMD_REWIND     = 3'd0,
        CMD_READ_SKIP  = 3'd1,
        CMD_SPACE_REV  = 3'd2,
        CMD_READ_DATA  = 3'd3,
        CMD_WRITE_DATA = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        PH_IDLE         = 3'd0,
        PH_REW_UNKNOWN  = 3'd1,
        PH_REW_THEN_FWD = 3'd2,
        PH_FWD          = 3'd3,
        PH_REV          = 3'd4,
        PH_XFER         = 3'd5
    } phase_t;

    // Result kinds
    localparam logic KIND_CMD  = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    typedef struct packed {
        logic [1:0]             req_type;
        logic [BLOCK_NUM_W-1:0] block_number;
        logic [1:0]             drive_status;
    } in_word_t;

    typedef struct packed {
        logic                   out_kind;
        logic [2:0]             drive_command;
        logic [STEP_TIME_W-1:0] step_time_ms;
        logic [1:0]             final_status;
    } out_word_t;

endpackage

`default_nettype wire

// File: sv/tbss_if.sv
// ----------------------------------------------------------------------------
// tbss_if: channel interfaces
// Request, response and configuration channels, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface tbss_req_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      req_type;
    logic [tbss_pkg::BLOCK_NUM_W-1:0] block_number;
    logic [1:0]                      drive_status;

    modport source (output valid, req_type, block_number, drive_status, input ready);
    modport sink   (input valid, req_type, block_number, drive_status, output ready);
endinterface

interface tbss_rsp_if;
    logic                            valid;
    logic                            ready;
    logic                            out_kind;
    logic [2:0]                      drive_command;
    logic [tbss_pkg::STEP_TIME_W-1:0] step_time_ms;
    logic [1:0]                      final_status;

    modport source (output valid, out_kind, drive_command, step_time_ms, final_status,
                    input ready);
    modport sink   (input valid, out_kind, drive_command, step_time_ms, final_status,
                    output ready);
endinterface

interface tbss_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [tbss_pkg::STEP_TIME_W-1:0] reverse_step_ms;

    modport source (output valid, reverse_step_ms, input ready);
    modport sink   (input valid, reverse_step_ms, output ready);
endinterface

`default_nettype wire

// File: sv/tbss_in_stage.sv
// ----------------------------------------------------------------------------
// tbss_in_stage: input register
// Captures one request word; frees itself when the core consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module tbss_in_stage (
    input  wire logic               clk,
    input  wire logic               rst_n,
    tbss_req_if.sink                req,
    input  wire logic               take,
    output tbss_pkg::in_word_t      held_word,
    output logic                    held_valid
);
    import tbss_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_word_t word_reg;
    logic     accept;

    // Slot is free when empty or being drained this cycle
    assign req.ready = !valid_reg || take;
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg.req_type     <= req.req_type;
            word_reg.block_number <= req.block_number;
            word_reg.drive_status <= req.drive_status;
        end
    end

    assign held_word  = word_reg;
    assign held_valid = valid_reg;

endmodule

`default_nettype wire

// File: sv/tbss_seek_core.sv
// ----------------------------------------------------------------------------
// tbss_seek_core: position tracking and seek sequencing
// Holds head position and request phase; turns one word into at most one
// drive command or completion per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tbss_seek_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               fire,
    input  wire tbss_pkg::in_word_t                 item,
    input  wire logic [tbss_pkg::STEP_TIME_W-1:0]   reverse_step_ms,
    output logic                                    res_valid,
    output tbss_pkg::out_word_t                     res
);
    import tbss_pkg::*;

    // State
    block_t head_reg,   head_next;
    logic   known_reg,  known_next;
    phase_t phase_reg,  phase_next;
    block_t target_reg, target_next;
    block_t steps_reg,  steps_next;
    logic   write_reg,  write_next;

    // Step decisions
    logic    emit_cmd;
    logic    emit_done;
    cmd_t    cmd;
    logic    do_plan;
    logic    do_data;
    block_t  item_blk;
    block_t  steps_dec;
    block_t  back_dist;
    status_t st;

    assign item_blk  = item.block_number[BLOCK_BITS-1:0];
    assign steps_dec = steps_reg - 1'b1;
    assign st        = status_t'(item.drive_status);

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            known_reg  <= 1'b0;
            phase_reg  <= PH_IDLE;
            target_reg <= '0;
            steps_reg  <= '0;
            write_reg  <= 1'b0;
        end
        else
        begin
            head_reg   <= head_next;
            known_reg  <= known_next;
            phase_reg  <= phase_next;
            target_reg <= target_next;
            steps_reg  <= steps_next;
            write_reg  <= write_next;
        end
    end

    // Next state and result
    always_comb
    begin
        head_next   = head_reg;
        known_next  = known_reg;
        phase_next  = phase_reg;
        target_next = target_reg;
        steps_next  = steps_reg;
        write_next  = write_reg;
        emit_cmd    = 1'b0;
        emit_done   = 1'b0;
        cmd         = CMD_REWIND;
        do_plan     = 1'b0;
        do_data     = 1'b0;
        back_dist   = '0;

        if (fire)
        begin
            case (req_code_t'(item.req_type))
                REQ_INVALIDATE:
                begin
                    known_next = 1'b0;
                end
                REQ_STATUS:
                begin
                    unique case (phase_reg)
                        PH_REW_UNKNOWN, PH_REW_THEN_FWD:
                        begin
                            if (st != ST_OK)
                            begin
                                if (phase_reg == PH_REW_THEN_FWD)
                                begin
                                    known_next = 1'b0;
                                end
                                emit_done = 1'b1;
                            end
                            else
                            begin
                                head_next  = '0;
                                known_next = 1'b1;
                                do_plan    = 1'b1;
                            end
                        end
                        PH_FWD:
                        begin
                            if (st == ST_LOAD_POINT || st == ST_ERROR)
                            begin
                                known_next = 1'b0;
                                emit_done  = 1'b1;
                            end
                            else
                            begin
                                if (known_reg)
                                begin
                                    head_next = head_reg + 1'b1;
                                end
                                steps_next = steps_dec;
                                if (steps_dec == '0)
                                begin
                                    do_data = 1'b1;
                                end
                                else
                                begin
                                    emit_cmd = 1'b1;
                                    cmd      = CMD_READ_SKIP;
                                end
                            end
                        end
                        PH_REV:
                        begin
                            if (st == ST_LOAD_POINT)
                            begin
                                head_next  = '0;
                                known_next = 1'b1;
                                do_data    = 1'b1;
                            end
                            else if (st != ST_OK)
                            begin
                                known_next = 1'b0;
                                emit_done  = 1'b1;
                            end
                            else
                            begin
                                // Never step below block zero
                                if (known_reg && head_reg != '0)
                                begin
                                    head_next = head_reg - 1'b1;
                                end
                                steps_next = steps_dec;
                                if (steps_dec == '0)
                                begin
                                    do_data = 1'b1;
                                end
                                else
                                begin
                                    emit_cmd = 1'b1;
                                    cmd      = CMD_SPACE_REV;
                                end
                            end
                        end
                        PH_XFER:
                        begin
                            // Parity is a good read, not a good write
                            if (st == ST_OK || (st == ST_PARITY && !write_reg))
                            begin
                                if (known_reg)
                                begin
                                    head_next = head_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                known_next = 1'b0;
                            end
                            emit_done = 1'b1;
                        end
                        default:
                        begin
                            // Status while idle is dropped
                        end
                    endcase
                end
                default:
                begin
                    // Read or write request, taken only while idle
                    if (phase_reg == PH_IDLE)
                    begin
                        target_next = item_blk;
                        write_next  = (req_code_t'(item.req_type) == REQ_WRITE);
                        steps_next  = '0;
                        if (!known_reg)
                        begin
                            phase_next = PH_REW_UNKNOWN;
                            emit_cmd   = 1'b1;
                            cmd        = CMD_REWIND;
                        end
                        else
                        begin
                            do_plan = 1'b1;
                        end
                    end
                end
            endcase
        end

        // Path choice from a known position
        if (do_plan)
        begin
            // Distance from the head back to the target
            back_dist = head_next - target_next;
            if (target_next == head_next)
            begin
                do_data = 1'b1;
            end
            else if (target_next > head_next)
            begin
                steps_next = target_next - head_next;
                phase_next = PH_FWD;
                emit_cmd   = 1'b1;
                cmd        = CMD_READ_SKIP;
            end
            else if (back_dist <= target_next)
            begin
                steps_next = back_dist;
                phase_next = PH_REV;
                emit_cmd   = 1'b1;
                cmd        = CMD_SPACE_REV;
            end
            else
            begin
                phase_next = PH_REW_THEN_FWD;
                emit_cmd   = 1'b1;
                cmd        = CMD_REWIND;
            end
        end

        // Data command
        if (do_data)
        begin
            phase_next = PH_XFER;
            emit_cmd   = 1'b1;
            cmd        = write_next ? CMD_WRITE_DATA : CMD_READ_DATA;
        end

        // Completion
        if (emit_done)
        begin
            phase_next = PH_IDLE;
        end
    end

    // Result word
    always_comb
    begin
        res_valid         = emit_cmd || emit_done;
        res.out_kind      = emit_done ? KIND_DONE : KIND_CMD;
        res.drive_command = emit_done ? CMD_REWIND : cmd;
        res.step_time_ms  = (emit_cmd && cmd == CMD_SPACE_REV) ? reverse_step_ms : '0;
        res.final_status  = emit_done ? item.drive_status : ST_OK;
    end

    // Checks
    a_result_needs_fire: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> fire)
        else $error("result without a consumed word");

    a_fwd_steps_live: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_FWD |-> steps_reg != '0)
        else $error("forward phase with no steps left");

    a_rev_steps_live: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_REV |-> steps_reg != '0)
        else $error("reverse phase with no steps left");

    a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        emit_done |=> phase_reg == PH_IDLE)
        else $error("completion did not return to idle");

    a_time_only_reverse: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.step_time_ms != '0 |-> res.drive_command == CMD_SPACE_REV)
        else $error("step time on a non-reverse word");

endmodule

`default_nettype wire

// File: sv/tbss_out_stage.sv
// ----------------------------------------------------------------------------
// tbss_out_stage: result register
// Holds one result word until the response channel takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module tbss_out_stage (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load,
    input  wire tbss_pkg::out_word_t load_word,
    output logic                    free,
    tbss_rsp_if.source              rsp
);
    import tbss_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_word_t word_reg;

    // Free when empty or being taken this cycle
    assign free = !valid_reg || rsp.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= load_word;
        end
    end

    assign rsp.valid         = valid_reg;
    assign rsp.out_kind      = word_reg.out_kind;
    assign rsp.drive_command = word_reg.drive_command;
    assign rsp.step_time_ms  = word_reg.step_time_ms;
    assign rsp.final_status  = word_reg.final_status;

endmodule

`default_nettype wire

// File: sv/tape_block_seek_sequencer.sv
// ----------------------------------------------------------------------------
// tape_block_seek_sequencer: tape head positioning sequencer
// Throughput: one word per cycle while the response side takes results; input
// register, one step of logic, result register, so a new word is taken while
// a result waits on the response side.
// Reset: position unknown, idle, step time 600 ms; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module tape_block_seek_sequencer (
    input  wire logic   clk,
    input  wire logic   rst_n,
    tbss_req_if.sink    req,
    tbss_rsp_if.source  rsp,
    tbss_cfg_if.sink    cfg
);
    import tbss_pkg::*;

    logic                   held_valid;
    in_word_t               held_word;
    logic                   out_free;
    logic                   fire;
    logic                   res_valid;
    out_word_t              res_word;
    logic [STEP_TIME_W-1:0] step_ms_reg;

    // Configuration register, always writable
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_ms_reg <= REVERSE_STEP_RESET;
        end
        else if (cfg.valid)
        begin
            step_ms_reg <= cfg.reverse_step_ms;
        end
    end

    // Process a held word when the result slot can take it
    assign fire = held_valid && out_free;

    tbss_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .take       (fire),
        .held_word  (held_word),
        .held_valid (held_valid)
    );

    tbss_seek_core u_seek_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .fire            (fire),
        .item            (held_word),
        .reverse_step_ms (step_ms_reg),
        .res_valid       (res_valid),
        .res             (res_word)
    );

    tbss_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .load_word (res_word),
        .free      (out_free),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

// File: dv/tape_block_seek_sequencer_test.sv
// ----------------------------------------------------------------------------
// tape_block_seek_sequencer_test: self-checking bench for the seek sequencer
// Drives request, invalidate and drive-status words with random gaps and
// response stalls. Each accepted word runs through a local model of the
// head tracker, and each response word is checked against the oldest
// expectation. The step time is changed between phases, while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tape_block_seek_sequencer_test;

    import tbss_pkg::*;

    // Model state of the head tracker
    typedef struct {
        block_t                 head;
        bit                     known;
        phase_t                 ph;
        block_t                 target;
        block_t                 steps;
        bit                     wr;
        logic [STEP_TIME_W-1:0] rev_ms;
    } seek_state_t;

    logic clk;
    logic rst_n;

    tbss_req_if req_bus ();
    tbss_rsp_if rsp_bus ();
    tbss_cfg_if cfg_bus ();

    tape_block_seek_sequencer uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus),
        .cfg   (cfg_bus)
    );

    seek_state_t track_state;   // follows accepted words, feeds the checker
    seek_state_t plan_state;    // follows queued words, steers the stimulus

    in_word_t  pending_words[$];
    out_word_t pending_results[$];

    bit req_taken;
    int gap_left;
    int hold_left;
    int quiet_left;
    int words_planned;
    int words_sent;
    int cmds_seen;
    int dones_seen;
    int faults;

    // ------------------------------------------------------------------
    // Head tracker model
    // ------------------------------------------------------------------
    function automatic out_word_t cmd_word(cmd_t c, logic [STEP_TIME_W-1:0] ms);
        out_word_t o;
        o = '0;
        o.out_kind = KIND_CMD;
        o.drive_command = c;
        if (c == CMD_SPACE_REV)
            o.step_time_ms = ms;
        return o;
    endfunction

    function automatic out_word_t finish(inout seek_state_t s, input status_t st);
        out_word_t o;
        o = '0;
        s.ph = PH_IDLE;
        o.out_kind = KIND_DONE;
        o.final_status = st;
        return o;
    endfunction

    function automatic out_word_t start_data(inout seek_state_t s);
        s.ph = PH_XFER;
        return cmd_word(s.wr ? CMD_WRITE_DATA : CMD_READ_DATA, s.rev_ms);
    endfunction

    // Position known: pick forward, reverse or rewind-then-forward
    function automatic out_word_t route_to_target(inout seek_state_t s);
        block_t back;
        if (s.target == s.head)
            return start_data(s);
        if (s.target > s.head)
        begin
            s.steps = s.target - s.head;
            s.ph = PH_FWD;
            return cmd_word(CMD_READ_SKIP, s.rev_ms);
        end
        back = s.head - s.target;
        if (back <= s.target)
        begin
            s.steps = back;
            s.ph = PH_REV;
            return cmd_word(CMD_SPACE_REV, s.rev_ms);
        end
        s.ph = PH_REW_THEN_FWD;
        return cmd_word(CMD_REWIND, s.rev_ms);
    endfunction

    // One input word; returns 1 when it yields a response word
    function automatic bit seek_step(inout seek_state_t s, input in_word_t w,
                                     output out_word_t r);
        status_t st;
        req_code_t req;
        bit has;
        st = status_t'(w.drive_status);
        req = req_code_t'(w.req_type);
        r = '0;
        has = 1'b1;
        if (req == REQ_INVALIDATE)
        begin
            s.known = 1'b0;
            has = 1'b0;
        end
        else if (req == REQ_STATUS)
        begin
            case (s.ph)
                PH_REW_UNKNOWN, PH_REW_THEN_FWD:
                begin
                    if (st != ST_OK)
                    begin
                        if (s.ph == PH_REW_THEN_FWD)
                            s.known = 1'b0;
                        r = finish(s, st);
                    end
                    else
                    begin
                        s.head = '0;
                        s.known = 1'b1;
                        r = route_to_target(s);
                    end
                end
                PH_FWD:
                begin
                    if (st == ST_LOAD_POINT || st == ST_ERROR)
                    begin
                        s.known = 1'b0;
                        r = finish(s, st);
                    end
                    else
                    begin
                        if (s.known)
                            s.head = s.head + 1'b1;
                        s.steps = s.steps - 1'b1;
                        if (s.steps == 0)
                            r = start_data(s);
                        else
                            r = cmd_word(CMD_READ_SKIP, s.rev_ms);
                    end
                end
                PH_REV:
                begin
                    if (st == ST_LOAD_POINT)
                    begin
                        s.head = '0;
                        s.known = 1'b1;
                        r = start_data(s);
                    end
                    else if (st != ST_OK)
                    begin
                        s.known = 1'b0;
                        r = finish(s, st);
                    end
                    else
                    begin
                        if (s.known && s.head != 0)
                            s.head = s.head - 1'b1;
                        s.steps = s.steps - 1'b1;
                        if (s.steps == 0)
                            r = start_data(s);
                        else
                            r = cmd_word(CMD_SPACE_REV, s.rev_ms);
                    end
                end
                PH_XFER:
                begin
                    if (st == ST_OK || (st == ST_PARITY && !s.wr))
                    begin
                        if (s.known)
                            s.head = s.head + 1'b1;
                    end
                    else
                        s.known = 1'b0;
                    r = finish(s, st);
                end
                default:
                    has = 1'b0;     // status while idle is dropped
            endcase
        end
        else if (s.ph != PH_IDLE)
            has = 1'b0;             // request while busy is dropped
        else
        begin
            s.target = w.block_number[BLOCK_BITS-1:0];
            s.wr = (req == REQ_WRITE);
            s.steps = '0;
            if (!s.known)
            begin
                s.ph = PH_REW_UNKNOWN;
                r = cmd_word(CMD_REWIND, s.rev_ms);
            end
            else
                r = route_to_target(s);
        end
        return has;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic int pause_len();
        int p;
        if (quiet_left > 0)
        begin
            quiet_left--;
            return 0;
        end
        p = $urandom_range(0, 199);
        if (p == 0)
        begin
            quiet_left = $urandom_range(30, 120);
            return 0;
        end
        if (p < 130)
            return 0;
        if (p < 190)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void queue_word(req_code_t req, logic [31:0] blk, status_t st);
        in_word_t w;
        out_word_t r;
        w.req_type = req;
        w.block_number = blk;
        w.drive_status = st;
        if (seek_step(plan_state, w, r) || req == REQ_INVALIDATE)
            words_planned++;
        pending_words.push_back(w);
    endfunction

    // Mostly well-formed request/status sequences, some noise
    function automatic void queue_random_word();
        int p;
        logic [31:0] blk;
        status_t st;
        p = $urandom_range(0, 99);
        blk = $urandom;
        st = status_t'($urandom_range(0, 3));
        if (p < 3)
            queue_word(REQ_INVALIDATE, blk, st);
        else if (p < 6)
            queue_word($urandom_range(0, 1) ? REQ_WRITE : REQ_READ, blk, st);
        else if (plan_state.ph == PH_IDLE)
        begin
            if (p < 10)
                queue_word(REQ_STATUS, blk, st);
            else
            begin
                if (plan_state.known && p < 60)
                    blk = plan_state.head + $urandom_range(0, 16) - 8;
                else if (p < 98)
                    blk = $urandom_range(0, 48);
                queue_word($urandom_range(0, 1) ? REQ_WRITE : REQ_READ, blk, st);
            end
        end
        else
        begin
            // long forward runs are cut short by a failing status
            if (plan_state.ph == PH_FWD && plan_state.steps > 64)
                st = $urandom_range(0, 1) ? ST_ERROR : ST_LOAD_POINT;
            else if (p < 82)
                st = ST_OK;
            else if (p < 89)
                st = ST_PARITY;
            else if (p < 95)
                st = ST_LOAD_POINT;
            else
                st = ST_ERROR;
            queue_word(REQ_STATUS, blk, st);
        end
    endfunction

    task automatic wait_drained();
        while (pending_words.size() != 0 || req_bus.valid || pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_step_time(input logic [STEP_TIME_W-1:0] v);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.reverse_step_ms <= v;
        do @(posedge clk); while (!cfg_bus.ready);
        track_state.rev_ms = v;
        plan_state.rev_ms = v;
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Request driver: one word from the queue, held until taken
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        in_word_t w;
        if (!rst_n)
            req_bus.valid <= 1'b0;
        else if (req_bus.valid && !req_taken)
        begin
            // word still waiting on ready
        end
        else if (gap_left > 0)
        begin
            req_bus.valid <= 1'b0;
            gap_left <= gap_left - 1;
        end
        else if (pending_words.size() > 0)
        begin
            w = pending_words.pop_front();
            req_bus.req_type <= w.req_type;
            req_bus.block_number <= w.block_number;
            req_bus.drive_status <= w.drive_status;
            req_bus.valid <= 1'b1;
            gap_left <= pause_len();
        end
        else
            req_bus.valid <= 1'b0;
    end

    // Response back-pressure
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_bus.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            rsp_bus.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
        begin
            rsp_bus.ready <= 1'b1;
            hold_left <= pause_len();
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check responses first, then model accepted words
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        out_word_t got;
        out_word_t want;
        out_word_t r;
        in_word_t w;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            got.out_kind = rsp_bus.out_kind;
            got.drive_command = rsp_bus.drive_command;
            got.step_time_ms = rsp_bus.step_time_ms;
            got.final_status = rsp_bus.final_status;
            if (got.out_kind == KIND_DONE)
                dones_seen++;
            else
                cmds_seen++;
            if (pending_results.size() == 0)
            begin
                faults++;
                if (faults <= 10)
                    $display("%0t: unexpected word kind=%0d cmd=%0d step=%0d status=%0d",
                             $time, got.out_kind, got.drive_command, got.step_time_ms,
                             got.final_status);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.out_kind !== want.out_kind ||
                    got.drive_command !== want.drive_command ||
                    got.step_time_ms !== want.step_time_ms ||
                    got.final_status !== want.final_status)
                begin
                    faults++;
                    if (faults <= 10)
                        $display("%0t: mismatch exp kind=%0d cmd=%0d step=%0d status=%0d",
                                 $time, want.out_kind, want.drive_command,
                                 want.step_time_ms, want.final_status,
                                 " got kind=%0d cmd=%0d step=%0d status=%0d",
                                 got.out_kind, got.drive_command, got.step_time_ms,
                                 got.final_status);
                end
            end
        end
        if (rst_n && req_bus.valid && req_bus.ready)
        begin
            w.req_type = req_bus.req_type;
            w.block_number = req_bus.block_number;
            w.drive_status = req_bus.drive_status;
            if (seek_step(track_state, w, r))
                pending_results.push_back(r);
            words_sent++;
        end
        req_taken <= rst_n && req_bus.valid && req_bus.ready;
    end

    // ------------------------------------------------------------------
    // Sequence: reset, directed words, then random phases per step time
    // ------------------------------------------------------------------
    initial
    begin
        logic [STEP_TIME_W-1:0] step_settings [5];
        int goal;
        step_settings = '{16'd1, 16'hFFFF, 16'hAAAA, 16'h5555,
                          STEP_TIME_W'($urandom_range(1, 65535))};
        rst_n = 1'b0;
        req_bus.valid = 1'b0;
        req_bus.req_type = REQ_READ;
        req_bus.block_number = '0;
        req_bus.drive_status = ST_OK;
        rsp_bus.ready = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.reverse_step_ms = '0;
        req_taken = 1'b0;
        gap_left = 0;
        hold_left = 0;
        quiet_left = 0;
        words_planned = 0;
        words_sent = 0;
        cmds_seen = 0;
        dones_seen = 0;
        faults = 0;
        track_state = '{head: '0, known: 1'b0, ph: PH_IDLE, target: '0, steps: '0,
                        wr: 1'b0, rev_ms: REVERSE_STEP_RESET};
        plan_state = track_state;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: idle status, busy request, parity on read and write,
        // target at head, reverse, a rewind error, invalidate mid-run,
        // largest target, rewind-then-forward phase ending at block zero
        queue_word(REQ_STATUS, 32'd0, ST_OK);
        queue_word(REQ_READ, 32'd1, ST_ERROR);
        queue_word(REQ_STATUS, 32'hFFFF_FFFF, ST_OK);
        queue_word(REQ_READ, 32'd0, ST_OK);
        queue_word(REQ_STATUS, 32'd0, ST_PARITY);
        queue_word(REQ_STATUS, 32'd0, ST_PARITY);
        queue_word(REQ_READ, 32'd2, ST_OK);
        queue_word(REQ_STATUS, 32'd0, ST_OK);
        queue_word(REQ_WRITE, 32'd2, ST_LOAD_POINT);
        queue_word(REQ_STATUS, 32'd0, ST_OK);
        queue_word(REQ_STATUS, 32'd0, ST_PARITY);
        queue_word(REQ_READ, 32'hFFFF_FFFF, ST_OK);
        queue_word(REQ_STATUS, 32'd0, ST_OK);
        queue_word(REQ_STATUS, 32'd0, ST_OK);
        queue_word(REQ_INVALIDATE, 32'hFFFF_FFFF, ST_ERROR);
        queue_word(REQ_STATUS, 32'd0, ST_PARITY);
        queue_word(REQ_STATUS, 32'd0, ST_ERROR);
        queue_word(REQ_WRITE, 32'd1, ST_OK);
        queue_word(REQ_STATUS, 32'd0, ST_LOAD_POINT);
        queue_word(REQ_READ, 32'd2, ST_OK);
        queue_word(REQ_STATUS, 32'd0, ST_OK);
        queue_word(REQ_STATUS, 32'd0, ST_OK);
        queue_word(REQ_STATUS, 32'd0, ST_OK);
        queue_word(REQ_STATUS, 32'd0, ST_OK);
        queue_word(REQ_WRITE, 32'd0, ST_OK);
        queue_word(REQ_STATUS, 32'd0, ST_OK);
        queue_word(REQ_STATUS, 32'd0, ST_ERROR);

        // Random phases: default step time first, then each setting
        for (int phase_idx = 0; phase_idx < 6; phase_idx++)
        begin
            if (phase_idx > 0)
            begin
                wait_drained();
                write_step_time(step_settings[phase_idx-1]);
            end
            goal = words_planned + 285;
            while (words_planned < goal || plan_state.ph != PH_IDLE)
                queue_random_word();
        end
        wait_drained();

        $display("Covered %0d input words giving %0d drive commands and %0d completions,",
                 words_sent, cmds_seen, dones_seen);
        $display("over six step-time settings from 1 to 65535 ms; %0d mismatches", faults);
        if (faults == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Run limit
    initial
    begin
        #15_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
